>>> rtl/core/dra_pkg.sv
// Shared types and constants for the DNS response address parser.
package dra_pkg;

    typedef enum logic [8:0] {
        PH_IDLE     = 9'b000000001,
        PH_HEADER   = 9'b000000010,
        PH_NAME_LEN = 9'b000000100,
        PH_NAME_CHR = 9'b000001000,
        PH_QTAIL    = 9'b000010000,
        PH_ANS_HDR  = 9'b000100000,
        PH_RDATA    = 9'b001000000,
        PH_DONE     = 9'b010000000,
        PH_PENDING  = 9'b100000000
    } t_phase;

    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_ADDR = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic       STATUS_OK       = 1'b0;
    localparam logic       STATUS_BAD_FLAG = 1'b1;

    localparam logic [15:0] FLAGS_OK   = 16'h8180;
    localparam logic [15:0] TYPE_A     = 16'h0001;
    localparam logic [15:0] RDLEN_A    = 16'd4;
    localparam logic [15:0] HDR_LEN    = 16'd12;
    localparam logic [15:0] QTAIL_LEN  = 16'd4;
    localparam logic [15:0] RR_HDR_LEN = 16'd12;
    localparam logic [7:0]  DOT_CHAR   = 8'h2E;

    // header / answer-header byte offsets
    localparam logic [15:0] OFS_FLAGS_HI = 16'd2;
    localparam logic [15:0] OFS_FLAGS_LO = 16'd3;
    localparam logic [15:0] OFS_ANCNT_HI = 16'd6;
    localparam logic [15:0] OFS_ANCNT_LO = 16'd7;
    localparam logic [15:0] OFS_TYPE_HI  = 16'd2;
    localparam logic [15:0] OFS_TYPE_LO  = 16'd3;
    localparam logic [15:0] OFS_RDLEN_HI = 16'd10;
    localparam logic [15:0] OFS_RDLEN_LO = 16'd11;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] field_count;
        logic [15:0] header_flags;
        logic [15:0] answer_total;
        logic [15:0] answers_done;
        logic [7:0]  label_left;
        logic        first_label;
        logic [15:0] record_type;
        logic [15:0] record_length;
        logic [31:0] addr_accum;
    } t_state;

    localparam t_state ST_RESET = '{
        phase:         PH_IDLE,
        field_count:   16'd0,
        header_flags:  16'd0,
        answer_total:  16'd0,
        answers_done:  16'd0,
        label_left:    8'd0,
        first_label:   1'b1,
        record_type:   16'd0,
        record_length: 16'd0,
        addr_accum:    32'd0
    };

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  name_char;
        logic [31:0] address;
        logic [2:0]  addr_index;
        logic        status;
    } t_result;

endpackage

>>> rtl/core/dra_step.sv
// Per-byte next-state and result logic of the DNS response parser.
module dra_step #(
    parameter int MAX_ADDRS = 8
) (
    input  dra_pkg::t_state                       i_state,
    input  logic [$clog2(MAX_ADDRS+1)-1:0]        i_addr_count,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_msg_start,
    output dra_pkg::t_state                       o_state,
    output logic [$clog2(MAX_ADDRS+1)-1:0]        o_addr_count,
    output logic                                  o_res_valid,
    output dra_pkg::t_result                      o_result
);

    localparam int CW = $clog2(MAX_ADDRS+1);

    dra_pkg::t_state  s;
    dra_pkg::t_result res;
    logic [CW-1:0]    cnt;
    logic [CW+2:0]    cnt_ext;
    logic             vld;
    logic             is_a;

    always_comb begin
        s       = i_state;
        cnt     = i_addr_count;
        vld     = 1'b0;
        res     = '0;
        is_a    = 1'b0;
        cnt_ext = (CW+3)'(i_addr_count);

        // deferred done after a final address
        if (s.phase == dra_pkg::PH_PENDING) begin
            vld      = 1'b1;
            res.kind = dra_pkg::KIND_DONE;
            s.phase  = dra_pkg::PH_DONE;
        end
        if (i_msg_start) begin
            s       = dra_pkg::ST_RESET;
            cnt     = '0;
            s.phase = dra_pkg::PH_HEADER;
        end

        case (s.phase)
            dra_pkg::PH_HEADER: begin
                if (s.field_count == dra_pkg::OFS_FLAGS_HI)
                    s.header_flags = {i_data_byte, 8'h00};
                else if (s.field_count == dra_pkg::OFS_FLAGS_LO)
                    s.header_flags = {s.header_flags[15:8], i_data_byte};
                else if (s.field_count == dra_pkg::OFS_ANCNT_HI)
                    s.answer_total = {i_data_byte, 8'h00};
                else if (s.field_count == dra_pkg::OFS_ANCNT_LO)
                    s.answer_total = {s.answer_total[15:8], i_data_byte};
                s.field_count = s.field_count + 16'd1;
                if (s.field_count == dra_pkg::HDR_LEN) begin
                    s.field_count = 16'd0;
                    s.first_label = 1'b1;
                    s.phase       = dra_pkg::PH_NAME_LEN;
                end
            end
            dra_pkg::PH_NAME_LEN: begin
                if (i_data_byte == 8'd0) begin
                    if (s.header_flags != dra_pkg::FLAGS_OK) begin
                        vld        = 1'b1;
                        res.kind   = dra_pkg::KIND_DONE;
                        res.status = dra_pkg::STATUS_BAD_FLAG;
                        s.phase    = dra_pkg::PH_DONE;
                    end else begin
                        s.field_count = 16'd0;
                        s.phase       = dra_pkg::PH_QTAIL;
                    end
                end else begin
                    if (!s.first_label) begin
                        vld           = 1'b1;
                        res.kind      = dra_pkg::KIND_CHAR;
                        res.name_char = dra_pkg::DOT_CHAR;
                    end
                    s.first_label = 1'b0;
                    s.label_left  = i_data_byte;
                    s.phase       = dra_pkg::PH_NAME_CHR;
                end
            end
            dra_pkg::PH_NAME_CHR: begin
                vld           = 1'b1;
                res.kind      = dra_pkg::KIND_CHAR;
                res.name_char = i_data_byte;
                s.label_left  = s.label_left - 8'd1;
                if (s.label_left == 8'd0)
                    s.phase = dra_pkg::PH_NAME_LEN;
            end
            dra_pkg::PH_QTAIL: begin
                s.field_count = s.field_count + 16'd1;
                if (s.field_count == dra_pkg::QTAIL_LEN) begin
                    s.field_count = 16'd0;
                    if (s.answer_total == 16'd0) begin
                        vld      = 1'b1;
                        res.kind = dra_pkg::KIND_DONE;
                        s.phase  = dra_pkg::PH_DONE;
                    end else begin
                        s.phase = dra_pkg::PH_ANS_HDR;
                    end
                end
            end
            dra_pkg::PH_ANS_HDR: begin
                if (s.field_count == dra_pkg::OFS_TYPE_HI)
                    s.record_type = {i_data_byte, 8'h00};
                else if (s.field_count == dra_pkg::OFS_TYPE_LO)
                    s.record_type = {s.record_type[15:8], i_data_byte};
                else if (s.field_count == dra_pkg::OFS_RDLEN_HI)
                    s.record_length = {i_data_byte, 8'h00};
                else if (s.field_count == dra_pkg::OFS_RDLEN_LO)
                    s.record_length = {s.record_length[15:8], i_data_byte};
                s.field_count = s.field_count + 16'd1;
                if (s.field_count == dra_pkg::RR_HDR_LEN) begin
                    s.field_count = 16'd0;
                    if (s.record_type == dra_pkg::TYPE_A &&
                        s.record_length == dra_pkg::RDLEN_A &&
                        cnt >= CW'(MAX_ADDRS)) begin
                        vld      = 1'b1;
                        res.kind = dra_pkg::KIND_DONE;
                        s.phase  = dra_pkg::PH_DONE;
                    end else if (s.record_length == 16'd0) begin
                        s.answers_done = s.answers_done + 16'd1;
                        if (s.answers_done == s.answer_total) begin
                            vld      = 1'b1;
                            res.kind = dra_pkg::KIND_DONE;
                            s.phase  = dra_pkg::PH_DONE;
                        end
                    end else begin
                        s.addr_accum = 32'd0;
                        s.phase      = dra_pkg::PH_RDATA;
                    end
                end
            end
            dra_pkg::PH_RDATA: begin
                is_a = (s.record_type == dra_pkg::TYPE_A) &&
                       (s.record_length == dra_pkg::RDLEN_A);
                if (is_a)
                    s.addr_accum = {s.addr_accum[23:0], i_data_byte};
                s.field_count = s.field_count + 16'd1;
                if (s.field_count == s.record_length) begin
                    s.field_count = 16'd0;
                    if (is_a) begin
                        vld            = 1'b1;
                        res.kind       = dra_pkg::KIND_ADDR;
                        res.address    = s.addr_accum;
                        res.addr_index = cnt_ext[2:0];
                        cnt            = cnt + CW'(1);
                    end
                    s.answers_done = s.answers_done + 16'd1;
                    if (s.answers_done == s.answer_total) begin
                        if (is_a) begin
                            s.phase = dra_pkg::PH_PENDING;
                        end else begin
                            vld      = 1'b1;
                            res.kind = dra_pkg::KIND_DONE;
                            s.phase  = dra_pkg::PH_DONE;
                        end
                    end else begin
                        s.phase = dra_pkg::PH_ANS_HDR;
                    end
                end
            end
            default: begin
            end
        endcase

        o_state      = s;
        o_addr_count = cnt;
        o_res_valid  = vld;
        o_result     = res;
    end

endmodule

>>> rtl/core/dns_response_address_parser.sv
// Top level of the DNS response address parser: request/result registers and state.
// A byte is held in the input register; its result is held in the output register.
// Throughput: one byte per cycle; the input register takes one more byte while
// a result waits, so the input side stalls only when both registers are full.
// Reset (i_rst_n low, synchronous): parser goes idle, counters clear, both
// registers empty; the first byte marked as message start begins parsing.
module dns_response_address_parser #(
    parameter int MAX_ADDRS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_msg_start,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_name_char,
    output logic [31:0] o_address,
    output logic [2:0]  o_addr_index,
    output logic        o_status
);

    localparam int CW = $clog2(MAX_ADDRS+1);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_start;
    dra_pkg::t_state  r_st;
    dra_pkg::t_state  n_st;
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic             r_out_valid;
    dra_pkg::t_result r_out;
    dra_pkg::t_result n_out;
    logic             w_res_valid;
    logic             w_adv;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = !r_in_valid || w_adv;

    dra_step #(
        .MAX_ADDRS (MAX_ADDRS)
    ) u_step (
        .i_state      (r_st),
        .i_addr_count (r_cnt),
        .i_data_byte  (r_in_byte),
        .i_msg_start  (r_in_start),
        .o_state      (n_st),
        .o_addr_count (n_cnt),
        .o_res_valid  (w_res_valid),
        .o_result     (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= dra_pkg::ST_RESET;
            r_cnt       <= '0;
        end else begin
            if (o_ready)
                r_in_valid <= i_valid;
            if (w_adv) begin
                r_out_valid <= r_in_valid && w_res_valid;
                if (r_in_valid) begin
                    r_st  <= n_st;
                    r_cnt <= n_cnt;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_start <= i_msg_start;
        end
        if (w_adv)
            r_out <= n_out;
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out.kind;
    assign o_name_char  = r_out.name_char;
    assign o_address    = r_out.address;
    assign o_addr_index = r_out.addr_index;
    assign o_status     = r_out.status;

    // a pending done is always delivered on the next processed byte
    a_pending_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && r_st.phase == dra_pkg::PH_PENDING) |=>
        (r_out_valid && r_out.kind == dra_pkg::KIND_DONE &&
         r_out.status == dra_pkg::STATUS_OK))
        else $error("pending done not emitted");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ADDRS))
        else $error("address count above limit");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_in_valid && r_out_valid && !i_ready))
        else $error("input stalled without a full pipeline");

    a_addr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == dra_pkg::KIND_ADDR) |->
        (o_status == dra_pkg::STATUS_OK && o_name_char == 8'd0))
        else $error("address result carries stray fields");

endmodule
